[hdl/q2rm_pkg.sv]
package q2rm_pkg;

    localparam int COMP_W   = 18;
    localparam int PROD_W   = 2 * COMP_W;
    localparam int SUM_W    = PROD_W + 2;
    localparam int NORM_W   = PROD_W + 1;
    localparam int REM_W    = NORM_W + 1;
    localparam int QUO_W    = 16;
    localparam int LANES    = 9;
    localparam int FRONT_STAGES = 2;
    localparam int LANE_STAGES  = QUO_W + 2;
    localparam int DEPTH    = FRONT_STAGES + LANE_STAGES;

    localparam logic signed [COMP_W-1:0] OUT_MAX = 18'sd131071;

    typedef logic signed [COMP_W-1:0] comp_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [NORM_W-1:0]        norm_t;
    typedef logic [REM_W-1:0]         rem_t;
    typedef logic [QUO_W-1:0]         quo_t;

    typedef struct packed {
        logic  neg;
        norm_t mag;
    } num_t;

endpackage

[hdl/q2rm_front.sv]
module q2rm_front (
    input  logic            clk,
    input  logic            en,
    input  q2rm_pkg::comp_t qw,
    input  q2rm_pkg::comp_t qx,
    input  q2rm_pkg::comp_t qy,
    input  q2rm_pkg::comp_t qz,
    output q2rm_pkg::num_t  num [q2rm_pkg::LANES],
    output q2rm_pkg::norm_t norm,
    output logic            zero
);
    import q2rm_pkg::*;

    // First stage: the ten products.
    prod_t ww_reg, xx_reg, yy_reg, zz_reg, xy_reg, zw_reg, xz_reg, yw_reg, yz_reg, xw_reg;
    // Second stage: numerator magnitudes, signs, the squared norm and its zero flag.
    num_t  num_reg [LANES];
    num_t  num_next [LANES];
    norm_t norm_reg;
    norm_t norm_next;
    logic  zero_reg;
    sum_t  s [LANES];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ww_reg <= qw * qw;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            zz_reg <= qz * qz;
            xy_reg <= qx * qy;
            zw_reg <= qz * qw;
            xz_reg <= qx * qz;
            yw_reg <= qy * qw;
            yz_reg <= qy * qz;
            xw_reg <= qx * qw;
        end
    end

    always_comb
    begin
        s[0] = SUM_W'(xx_reg) - SUM_W'(yy_reg) - SUM_W'(zz_reg) + SUM_W'(ww_reg);
        s[1] = (SUM_W'(xy_reg) - SUM_W'(zw_reg)) <<< 1;
        s[2] = (SUM_W'(xz_reg) + SUM_W'(yw_reg)) <<< 1;
        s[3] = (SUM_W'(xy_reg) + SUM_W'(zw_reg)) <<< 1;
        s[4] = SUM_W'(yy_reg) - SUM_W'(xx_reg) - SUM_W'(zz_reg) + SUM_W'(ww_reg);
        s[5] = (SUM_W'(yz_reg) - SUM_W'(xw_reg)) <<< 1;
        s[6] = (SUM_W'(xz_reg) - SUM_W'(yw_reg)) <<< 1;
        s[7] = (SUM_W'(yz_reg) + SUM_W'(xw_reg)) <<< 1;
        s[8] = SUM_W'(zz_reg) - SUM_W'(xx_reg) - SUM_W'(yy_reg) + SUM_W'(ww_reg);
        for (int i = 0; i < LANES; i++)
        begin
            num_next[i].neg = s[i][SUM_W-1];
            num_next[i].mag = s[i][SUM_W-1] ? NORM_W'(-s[i]) : NORM_W'(s[i]);
        end
        norm_next = NORM_W'(ww_reg) + NORM_W'(xx_reg) + NORM_W'(yy_reg) + NORM_W'(zz_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg  <= num_next;
            norm_reg <= norm_next;
            zero_reg <= (norm_next == '0);
        end
    end

    assign num  = num_reg;
    assign norm = norm_reg;
    assign zero = zero_reg;

endmodule

[hdl/q2rm_div_lane.sv]
module q2rm_div_lane (
    input  logic            clk,
    input  logic            en,
    input  q2rm_pkg::num_t  num,
    input  q2rm_pkg::norm_t norm,
    output q2rm_pkg::comp_t entry
);
    import q2rm_pkg::*;

    // Restoring division, one quotient bit per stage, most significant first.
    rem_t  rem_reg  [QUO_W+1];
    quo_t  quo_reg  [QUO_W+1];
    norm_t den_reg  [QUO_W+1];
    logic  neg_reg  [QUO_W+1];
    comp_t entry_reg;
    comp_t entry_next;
    logic [QUO_W:0] rnd;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= REM_W'(num.mag);
            quo_reg[0] <= '0;
            den_reg[0] <= norm;
            neg_reg[0] <= num.neg;
        end
    end

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_step
        rem_t trial;
        rem_t part;
        logic bit_q;

        always_comb
        begin
            part  = (k == 0) ? rem_reg[k] : (rem_reg[k] << 1);
            bit_q = (part >= REM_W'(den_reg[k]));
            trial = bit_q ? (part - REM_W'(den_reg[k])) : part;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= trial;
                quo_reg[k+1] <= {quo_reg[k][QUO_W-2:0], bit_q};
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    // Round half away from zero from the extra quotient bit, then clamp and sign.
    always_comb
    begin
        rnd = ((QUO_W+1)'(quo_reg[QUO_W]) + 1'b1) >> 1;
        if (rnd > (QUO_W+1)'(OUT_MAX))
        begin
            entry_next = neg_reg[QUO_W] ? -OUT_MAX - 18'sd1 : OUT_MAX;
        end
        else
        begin
            entry_next = neg_reg[QUO_W] ? -COMP_W'(rnd) : COMP_W'(rnd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            entry_reg <= entry_next;
        end
    end

    assign entry = entry_reg;

endmodule

[hdl/quaternion_to_rotation_matrix_top.sv]
// Quaternion to 3x3 rotation matrix converter.
// The input channel carries one quaternion (qw, qx, qy, qz) in signed Q3.14 per
// transaction; the output channel carries the nine matrix entries m00..m22 in
// signed Q3.14 and a degenerate flag, which is set, with all entries zero,
// when the quaternion is all zero. Entries are divided by the squared norm,
// so quaternions of any length give a proper rotation, rounded to nearest.
// On its way from input acceptance to a valid result, a transaction passes
// through one stage of multipliers, one stage of sums, a lane input stage,
// sixteen restoring division stages (one quotient bit each, nine lanes in
// parallel) and a rounding stage.
// Throughput is one transaction per cycle while the output is not stalled.
// When the receiver stalls a waiting result, the whole pipeline freezes and
// in_stall is raised, so no transaction is lost or repeated; bubbles travel
// along with the valid bits. Reset clears the valid bits only; the data
// registers hold whatever they held and are ignored until refilled.
module quaternion_to_rotation_matrix_top (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  q2rm_pkg::comp_t qw,
    input  q2rm_pkg::comp_t qx,
    input  q2rm_pkg::comp_t qy,
    input  q2rm_pkg::comp_t qz,
    output logic            out_valid,
    input  logic            out_stall,
    output q2rm_pkg::comp_t m00,
    output q2rm_pkg::comp_t m01,
    output q2rm_pkg::comp_t m02,
    output q2rm_pkg::comp_t m10,
    output q2rm_pkg::comp_t m11,
    output q2rm_pkg::comp_t m12,
    output q2rm_pkg::comp_t m20,
    output q2rm_pkg::comp_t m21,
    output q2rm_pkg::comp_t m22,
    output logic            degenerate
);
    import q2rm_pkg::*;

    logic  adv;
    num_t  num [LANES];
    norm_t norm;
    logic  zero;
    comp_t entry [LANES];
    logic  vld_reg [DEPTH];
    logic  deg_reg [LANE_STAGES];

    // The pipeline moves unless a finished result is being held back.
    assign adv      = !(vld_reg[DEPTH-1] && out_stall);
    assign in_stall = !adv;

    q2rm_front u_front (
        .clk  (clk),
        .en   (adv),
        .qw   (qw),
        .qx   (qx),
        .qy   (qy),
        .qz   (qz),
        .num  (num),
        .norm (norm),
        .zero (zero)
    );

    for (genvar i = 0; i < LANES; i++)
    begin : g_lane
        q2rm_div_lane u_lane (
            .clk   (clk),
            .en    (adv),
            .num   (num[i]),
            .norm  (norm),
            .entry (entry[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // The zero-norm flag follows its transaction through the division lanes.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            deg_reg[0] <= zero;
            for (int i = 1; i < LANE_STAGES; i++)
            begin
                deg_reg[i] <= deg_reg[i-1];
            end
        end
    end

    assign out_valid  = vld_reg[DEPTH-1];
    assign degenerate = deg_reg[LANE_STAGES-1];
    assign m00 = degenerate ? '0 : entry[0];
    assign m01 = degenerate ? '0 : entry[1];
    assign m02 = degenerate ? '0 : entry[2];
    assign m10 = degenerate ? '0 : entry[3];
    assign m11 = degenerate ? '0 : entry[4];
    assign m12 = degenerate ? '0 : entry[5];
    assign m20 = degenerate ? '0 : entry[6];
    assign m21 = degenerate ? '0 : entry[7];
    assign m22 = degenerate ? '0 : entry[8];

endmodule
